>>> rtl/rgbcct_pkg.sv
// ----------------------------------------------------------------------------
// rgbcct_pkg: shared constants and types
// Fixed-point constants for the RGB to XYZ matrix and McCamy's cubic, and the
// sideband record that travels beside the data through the pipeline.
// ----------------------------------------------------------------------------
package rgbcct_pkg;

  localparam int unsigned CH_W = 16;

  // RGB to XYZ matrix, signed Q2.14, rows X, Y, Z and columns R, G, B
  localparam logic signed [16:0] MAT [0:2][0:2] = '{
    '{-17'sd2340,  17'sd25383, -17'sd15670},
    '{-17'sd5319,  17'sd25860, -17'sd11992},
    '{-17'sd11174, 17'sd12628,  17'sd9229}
  };

  // McCamy epicenter, Q16
  localparam logic signed [32:0] MC_XE = 33'sd21758;
  localparam logic signed [32:0] MC_YE = 33'sd12177;

  // Polynomial coefficients
  localparam logic signed [29:0] MC_C1 = 30'sd447171789;  // 6823.3 in Q16
  localparam logic signed [47:0] MC_C0 = 48'sd361780347;  // 5520.33 in Q16
  localparam logic signed [12:0] MC_K2 = 13'sd3525;
  localparam logic signed [9:0]  MC_K3 = 10'sd449;

  // Sideband that rides beside each item
  typedef struct packed {
    logic [CH_W-1:0] lux;
    logic            lux_clamp;
    logic            fault;
  } side_t;

endpackage

>>> rtl/rgbcct_div.sv
// ----------------------------------------------------------------------------
// rgbcct_div: pipelined restoring divider
// Unsigned quotient one bit per stage, with an overflow flag when the quotient
// does not fit QW bits. A sideband word travels with each item.
// ----------------------------------------------------------------------------
module rgbcct_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 34,
  parameter int unsigned QW = 31,
  parameter int unsigned PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [PW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic [PW-1:0] side_out
);
  localparam int unsigned HW = NW - QW;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  logic [QW:0]   v;
  logic [DW-1:0] rem [0:QW];
  logic [QW-1:0] lo  [0:QW];
  logic [QW-1:0] q   [0:QW];
  logic [DW-1:0] d   [0:QW];
  logic          o   [0:QW];
  logic [PW-1:0] sd  [0:QW];

  logic [CW-1:0] hi_x;
  logic [CW-1:0] den_x;
  logic          ovf0;

  assign hi_x  = CW'(num[NW-1:QW]);
  assign den_x = CW'(den);
  assign ovf0  = hi_x >= den_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v[0] <= in_valid;
      for (int k = 1; k <= QW; k++) begin
        v[k] <= v[k-1];
      end
    end
  end

  // Stage 0: overflow check, load the upper dividend bits as remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= ovf0 ? '0 : hi_x[DW-1:0];
      lo[0]  <= num[QW-1:0];
      q[0]   <= '0;
      d[0]   <= den;
      o[0]   <= ovf0;
      sd[0]  <= side_in;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_bit
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem[k-1], lo[k-1][QW-1]};
    assign diff  = trial - {1'b0, d[k-1]};
    assign ge    = trial >= {1'b0, d[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        lo[k]  <= lo[k-1] << 1;
        q[k]   <= {q[k-1][QW-2:0], ge};
        d[k]   <= d[k-1];
        o[k]   <= o[k-1];
        sd[k]  <= sd[k-1];
      end
    end
  end

  assign out_valid = v[QW];
  assign quo       = q[QW];
  assign ovf       = o[QW];
  assign side_out  = sd[QW];

endmodule

>>> rtl/rgb_to_colour_temperature_lux.sv
// ----------------------------------------------------------------------------
// rgb_to_colour_temperature_lux: colour temperature and lux from RGB counts
// Maps a red, green, blue triple to XYZ, forms the chromaticities x and y,
// applies McCamy's cubic for the correlated colour temperature and reports
// the Y row as illuminance. Results saturate to 16 bits with a clamp flag.
//
//   channel | dir | tdata fields (lowest bit first)
//   --------+-----+----------------------------------------------------------
//   s_      | in  | red[15:0], green[31:16], blue[47:32]
//   m_      | out | colour_temperature[15:0], illuminance[31:16],
//           |     | divide_fault[32], clamped[33], zero pad[39:34]
//
// One item enters every cycle unless the output stalls. Most of the depth lies in
// the restoring dividers (32 stages for x and y, 23 stages for n).
// All stages advance together when the output register is empty or taken;
// a stall holds every stage in place. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module rgb_to_colour_temperature_lux (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // red, green, blue
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // colour_temperature, illuminance, divide_fault,
                                 // clamped, zero pad
);
  import rgbcct_pkg::*;

  logic en;

  // Advance the whole pipeline when the output slot frees up
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // --------------------------------------------------------------------------
  // Stage A: nine matrix products
  // --------------------------------------------------------------------------
  logic               va;
  logic signed [31:0] prod [0:2][0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= 32'(MAT[r][c]) * 32'($signed({1'b0, s_tdata[c*CH_W +: CH_W]}));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: row sums give X, Y, Z with 14 fraction bits
  // --------------------------------------------------------------------------
  logic               vb;
  logic signed [31:0] t0_b, t1_b, t2_b;

  always_ff @(posedge clk) begin
    if (en) begin
      t0_b <= prod[0][0] + prod[0][1] + prod[0][2];
      t1_b <= prod[1][0] + prod[1][1] + prod[1][2];
      t2_b <= prod[2][0] + prod[2][1] + prod[2][2];
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: sum S, illuminance from Y
  // --------------------------------------------------------------------------
  logic               vc;
  logic signed [31:0] t0_c, t1_c;
  logic signed [33:0] s_c;
  logic [CH_W-1:0]    lux_c;
  logic               lux_clamp_c;
  logic [CH_W-1:0]    lux_next;
  logic               lux_clamp_next;

  always_comb begin
    if (t1_b < -32'sd16383) begin
      lux_next       = '0;
      lux_clamp_next = 1'b1;
    end else if (t1_b[31]) begin
      lux_next       = '0;
      lux_clamp_next = 1'b0;
    end else if (t1_b[30]) begin
      lux_next       = '1;
      lux_clamp_next = 1'b1;
    end else begin
      lux_next       = t1_b[29:14];
      lux_clamp_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_c        <= t0_b;
      t1_c        <= t1_b;
      s_c         <= 34'(t0_b) + 34'(t1_b) + 34'(t2_b);
      lux_c       <= lux_next;
      lux_clamp_c <= lux_clamp_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: magnitudes and signs for the chromaticity division
  // --------------------------------------------------------------------------
  logic        vd;
  logic [31:0] t0_abs_d, t1_abs_d;
  logic [33:0] s_abs_d;
  logic        sign_x_d, sign_y_d;
  side_t       side_d;

  always_ff @(posedge clk) begin
    if (en) begin
      t0_abs_d         <= t0_c[31] ? 32'(-t0_c) : 32'(t0_c);
      t1_abs_d         <= t1_c[31] ? 32'(-t1_c) : 32'(t1_c);
      s_abs_d          <= s_c[33] ? 34'(-s_c) : 34'(s_c);
      sign_x_d         <= t0_c[31] ^ s_c[33];
      sign_y_d         <= t1_c[31] ^ s_c[33];
      side_d.lux       <= lux_c;
      side_d.lux_clamp <= lux_clamp_c;
      side_d.fault     <= (s_c == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Chromaticity dividers: x = X*2^16/S and y = Y*2^16/S
  // --------------------------------------------------------------------------
  localparam int unsigned XY_QW = 31;
  localparam int unsigned SIDE_W = $bits(side_t);

  logic                    vx, vy;
  logic [XY_QW-1:0]        xq, yq;
  logic                    xovf, yovf;
  logic [SIDE_W:0]         xside;
  logic                    ysign;

  rgbcct_div #(.NW(48), .DW(34), .QW(XY_QW), .PW(SIDE_W + 1)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vd),
    .num      ({t0_abs_d, 16'b0}),
    .den      (s_abs_d),
    .side_in  ({sign_x_d, side_d}),
    .out_valid(vx),
    .quo      (xq),
    .ovf      (xovf),
    .side_out (xside)
  );

  rgbcct_div #(.NW(48), .DW(34), .QW(XY_QW), .PW(1)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vd),
    .num      ({t1_abs_d, 16'b0}),
    .den      (s_abs_d),
    .side_in  (sign_y_d),
    .out_valid(vy),
    .quo      (yq),
    .ovf      (yovf),
    .side_out (ysign)
  );

  // --------------------------------------------------------------------------
  // Stage E: signed, saturated chromaticities
  // --------------------------------------------------------------------------
  logic               ve;
  logic signed [31:0] xc_e, yc_e;
  side_t              side_e;

  always_ff @(posedge clk) begin
    if (en) begin
      if (xside[SIDE_W]) begin
        xc_e <= xovf ? 32'sh8000_0000 : -$signed({1'b0, xq});
      end else begin
        xc_e <= xovf ? 32'sh7fff_ffff : $signed({1'b0, xq});
      end
      if (ysign) begin
        yc_e <= yovf ? 32'sh8000_0000 : -$signed({1'b0, yq});
      end else begin
        yc_e <= yovf ? 32'sh7fff_ffff : $signed({1'b0, yq});
      end
      side_e <= side_t'(xside[SIDE_W-1:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: McCamy numerator and denominator
  // --------------------------------------------------------------------------
  logic               vf;
  logic signed [32:0] num_f, den_f;
  side_t              side_f;

  always_ff @(posedge clk) begin
    if (en) begin
      num_f  <= 33'(xc_e) - MC_XE;
      den_f  <= MC_YE - 33'(yc_e);
      side_f <= side_e;
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: magnitudes for the n division, zero divisor fault
  // --------------------------------------------------------------------------
  logic        vg;
  logic [32:0] num_abs_g, den_abs_g;
  logic        sign_n_g;
  side_t       side_g;

  always_ff @(posedge clk) begin
    if (en) begin
      num_abs_g        <= num_f[32] ? 33'(-num_f) : 33'(num_f);
      den_abs_g        <= den_f[32] ? 33'(-den_f) : 33'(den_f);
      sign_n_g         <= num_f[32] ^ den_f[32];
      side_g.lux       <= side_f.lux;
      side_g.lux_clamp <= side_f.lux_clamp;
      side_g.fault     <= side_f.fault || (den_f == '0);
    end
  end

  // --------------------------------------------------------------------------
  // n divider: n = num*2^16/den, saturated at 2^22
  // --------------------------------------------------------------------------
  localparam int unsigned N_QW = 22;

  logic              vn;
  logic [N_QW-1:0]   nq;
  logic              novf;
  logic [SIDE_W:0]   nside;

  rgbcct_div #(.NW(49), .DW(33), .QW(N_QW), .PW(SIDE_W + 1)) u_div_n (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vg),
    .num      ({num_abs_g, 16'b0}),
    .den      (den_abs_g),
    .side_in  ({sign_n_g, side_g}),
    .out_valid(vn),
    .quo      (nq),
    .ovf      (novf),
    .side_out (nside)
  );

  // --------------------------------------------------------------------------
  // Stage H: signed n in Q16, limited to +-64
  // --------------------------------------------------------------------------
  logic               vh;
  logic signed [23:0] n_h;
  side_t              side_h;
  logic [23:0]        n_mag;

  assign n_mag = novf ? 24'(1 << N_QW) : {2'b00, nq};

  always_ff @(posedge clk) begin
    if (en) begin
      n_h    <= nside[SIDE_W] ? -$signed(n_mag) : $signed(n_mag);
      side_h <= side_t'(nside[SIDE_W-1:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage P1: n^2 and n*C1 products
  // --------------------------------------------------------------------------
  logic               vp1;
  logic signed [47:0] sq_p1;
  logic signed [53:0] m1_p1;
  logic signed [23:0] n_p1;
  side_t              side_p1;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_p1   <= n_h * n_h;
      m1_p1   <= n_h * MC_C1;
      n_p1    <= n_h;
      side_p1 <= side_h;
    end
  end

  // --------------------------------------------------------------------------
  // Stage P2: drop 16 fraction bits, truncating toward zero
  // --------------------------------------------------------------------------
  logic               vp2;
  logic signed [29:0] n2_p2;
  logic signed [37:0] c1t_p2;
  logic signed [23:0] n_p2;
  side_t              side_p2;
  logic signed [53:0] m1_bias;

  assign m1_bias = m1_p1 + (m1_p1[53] ? 54'sd65535 : 54'sd0);

  always_ff @(posedge clk) begin
    if (en) begin
      n2_p2   <= $signed({1'b0, sq_p1[44:16]});
      c1t_p2  <= m1_bias[53:16];
      n_p2    <= n_p1;
      side_p2 <= side_p1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage P3: n^2 * n product and the square term
  // --------------------------------------------------------------------------
  logic               vp3;
  logic signed [53:0] cu_p3;
  logic signed [47:0] sqt_p3;
  logic signed [37:0] c1t_p3;
  side_t              side_p3;

  always_ff @(posedge clk) begin
    if (en) begin
      cu_p3   <= n2_p2 * n_p2;
      sqt_p3  <= 48'(n2_p2) * 48'(MC_K2);
      c1t_p3  <= c1t_p2;
      side_p3 <= side_p2;
    end
  end

  // --------------------------------------------------------------------------
  // Stage P4: n^3 truncated toward zero, partial sum of lower terms
  // --------------------------------------------------------------------------
  logic               vp4;
  logic signed [37:0] n3_p4;
  logic signed [47:0] part_p4;
  side_t              side_p4;
  logic signed [53:0] cu_bias;

  assign cu_bias = cu_p3 + (cu_p3[53] ? 54'sd65535 : 54'sd0);

  always_ff @(posedge clk) begin
    if (en) begin
      n3_p4   <= cu_bias[53:16];
      part_p4 <= sqt_p3 + 48'(c1t_p3) + MC_C0;
      side_p4 <= side_p3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage P5: cubic term
  // --------------------------------------------------------------------------
  logic               vp5;
  logic signed [47:0] cub_p5;
  logic signed [47:0] part_p5;
  side_t              side_p5;

  always_ff @(posedge clk) begin
    if (en) begin
      cub_p5  <= 48'(n3_p4) * 48'(MC_K3);
      part_p5 <= part_p4;
      side_p5 <= side_p4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage P6: full polynomial in Q16
  // --------------------------------------------------------------------------
  logic               vp6;
  logic signed [47:0] acc_p6;
  side_t              side_p6;

  always_ff @(posedge clk) begin
    if (en) begin
      acc_p6  <= cub_p5 + part_p5;
      side_p6 <= side_p5;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: truncate to kelvin, saturate, pack the result
  // --------------------------------------------------------------------------
  logic signed [47:0] acc_bias;
  logic signed [31:0] cct_int;
  logic [CH_W-1:0]    cct_next;
  logic               cct_clamp;

  assign acc_bias = acc_p6 + (acc_p6[47] ? 48'sd65535 : 48'sd0);
  assign cct_int  = acc_bias[47:16];

  always_comb begin
    if (side_p6.fault) begin
      cct_next  = '0;
      cct_clamp = 1'b0;
    end else if (cct_int[31]) begin
      cct_next  = '0;
      cct_clamp = 1'b1;
    end else if (cct_int > 32'sd65535) begin
      cct_next  = '1;
      cct_clamp = 1'b1;
    end else begin
      cct_next  = cct_int[CH_W-1:0];
      cct_clamp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {6'b0, side_p6.lux_clamp | cct_clamp, side_p6.fault,
                  side_p6.lux, cct_next};
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits: advance with the data, clear on reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      vd       <= 1'b0;
      ve       <= 1'b0;
      vf       <= 1'b0;
      vg       <= 1'b0;
      vh       <= 1'b0;
      vp1      <= 1'b0;
      vp2      <= 1'b0;
      vp3      <= 1'b0;
      vp4      <= 1'b0;
      vp5      <= 1'b0;
      vp6      <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      va       <= s_tvalid;
      vb       <= va;
      vc       <= vb;
      vd       <= vc;
      ve       <= vx;
      vf       <= ve;
      vg       <= vf;
      vh       <= vn;
      vp1      <= vh;
      vp2      <= vp1;
      vp3      <= vp2;
      vp4      <= vp3;
      vp5      <= vp4;
      vp6      <= vp5;
      m_tvalid <= vp6;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The x and y dividers see the same items, so their valids must agree
  a_xy_align: assert property (@(posedge clk) disable iff (rst) vx == vy)
    else $error("x and y dividers out of step");

  // n never leaves the +-64 range in Q16
  a_n_range: assert property (@(posedge clk) disable iff (rst)
    vh |-> (n_h <= 24'sd4194304 && n_h >= -24'sd4194304))
    else $error("n outside saturation range");

  // A divide fault always reports a zero temperature
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[32]) |-> (m_tdata[15:0] == '0))
    else $error("fault with nonzero temperature");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rgb_to_colour_temperature_lux
// Drives red, green, blue triples on the input stream, predicts colour
// temperature, illuminance and the fault and clamp flags for each accepted
// item, and compares every output item in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbcct_pkg::*;

  // Expected output item
  typedef struct packed {
    logic [15:0] cct;
    logic [15:0] lux;
    logic        fault;
    logic        clamp;
  } cct_lux_t;

  // Predict one output item from a triple (fixed-point McCamy)
  function automatic cct_lux_t predict_cct_lux(logic [15:0] r, logic [15:0] g,
                                              logic [15:0] b);
    longint t [3];
    longint ch [3];
    longint s, xc, yc, den, num, n, n2, n3, acc, lx, ct;
    cct_lux_t res;
    ch[0] = r; ch[1] = g; ch[2] = b;
    res = '0;
    for (int i = 0; i < 3; i++)
      t[i] = longint'(MAT[i][0]) * ch[0] + longint'(MAT[i][1]) * ch[1]
           + longint'(MAT[i][2]) * ch[2];
    // Illuminance: Y row, truncated toward zero
    lx = t[1] / 16384;
    if (lx < 0) begin
      res.lux = 0; res.clamp = 1;
    end else if (lx > 65535) begin
      res.lux = 16'hFFFF; res.clamp = 1;
    end else begin
      res.lux = lx[15:0];
    end
    s = t[0] + t[1] + t[2];
    if (s == 0) begin
      res.fault = 1;
    end else begin
      xc = (t[0] * 65536) / s;
      yc = (t[1] * 65536) / s;
      // Saturate chromaticities quietly to Q15.16
      if (xc > 64'sd2147483647) xc = 64'sd2147483647;
      if (xc < -64'sd2147483648) xc = -64'sd2147483648;
      if (yc > 64'sd2147483647) yc = 64'sd2147483647;
      if (yc < -64'sd2147483648) yc = -64'sd2147483648;
      den = longint'(MC_YE) - yc;
      if (den == 0) begin
        res.fault = 1;
      end else begin
        num = xc - longint'(MC_XE);
        n = (num * 65536) / den;
        if (n > 4194304) n = 4194304;
        if (n < -4194304) n = -4194304;
        n2 = (n * n) / 65536;
        n3 = (n2 * n) / 65536;
        acc = longint'(MC_K3) * n3 + longint'(MC_K2) * n2
            + (n * longint'(MC_C1)) / 65536 + longint'(MC_C0);
        ct = acc / 65536;
        if (ct < 0) begin
          res.cct = 0; res.clamp = 1;
        end else if (ct > 65535) begin
          res.cct = 16'hFFFF; res.clamp = 1;
        end else begin
          res.cct = ct[15:0];
        end
      end
    end
    return res;
  endfunction

  // Queue of expected items and the comparison against the output stream
  class cct_lux_board;
    cct_lux_t pending [$];
    int mismatches;
    int checked;

    function void note_triple(logic [47:0] d);
      pending.push_back(predict_cct_lux(d[15:0], d[31:16], d[47:32]));
    endfunction

    function void check_item(logic [39:0] d);
      cct_lux_t want;
      cct_lux_t got;
      got = {d[15:0], d[31:16], d[32], d[33]};
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected output item %h", d);
        return;
      end
      want = pending.pop_front();
      if (got !== want || d[39:34] !== 6'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: item %0d cct exp %0d got %0d, lux exp %0d got %0d, fault exp %b got %b, clamp exp %b got %b",
                   checked, want.cct, got.cct, want.lux, got.lux, want.fault,
                   got.fault, want.clamp, got.clamp);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;

  cct_lux_board board = new();
  int send_idle_pct = 25;   // percent of cycles the sender holds off
  int recv_idle_pct = 59;   // percent of cycles the receiver stalls
  bit hold_off = 0;         // long receiver stall to fill the pipeline
  bit sending_done = 0;

  rgb_to_colour_temperature_lux dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Hard limit on run time
  initial begin
    #5ms;
    $display("rgb_to_colour_temperature_lux test failed");
    $finish;
  end

  // Score accepted items on both streams
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.note_triple(s_tdata);
    if (!rst && m_tvalid && m_tready) board.check_item(m_tdata);
  end

  // Receiver: random stalls, or a full stall while hold_off is set
  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one triple and hold it until accepted, with random gaps before it
  task automatic send_triple(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {b, g, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Random channel value: mostly full range, sometimes an extreme or a small value
  function automatic logic [15:0] rand_count();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        // Near-grey triples keep n small and the temperature in range
        logic [15:0] base;
        base = 16'($urandom);
        send_triple(base, base + 16'($urandom_range(2000)),
                    base - 16'($urandom_range(2000)));
      end else begin
        send_triple(rand_count(), rand_count(), rand_count());
      end
    end
  endtask

  // Long receiver hold-off, counted in its own process
  initial begin
    @(negedge rst);
    repeat (300) @(posedge clk);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    int drain;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, zero sum, pure channels, grey, lux clamping
    send_triple(16'h0000, 16'h0000, 16'h0000);   // zero sum: fault
    send_triple(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_triple(16'hFFFF, 16'h0000, 16'h0000);   // negative lux
    send_triple(16'h0000, 16'hFFFF, 16'h0000);   // lux above range
    send_triple(16'h0000, 16'h0000, 16'hFFFF);
    send_triple(16'h0001, 16'h0000, 16'h0000);
    send_triple(16'h0000, 16'h0001, 16'h0000);
    send_triple(16'h0000, 16'h0000, 16'h0001);
    send_triple(16'h5555, 16'hAAAA, 16'h5555);
    send_triple(16'hAAAA, 16'h5555, 16'hAAAA);
    send_triple(16'd1000, 16'd1000, 16'd1000);   // grey
    send_triple(16'd4000, 16'd3000, 16'd2000);   // warm
    send_triple(16'd2000, 16'd3000, 16'd4000);   // cool
    send_triple(16'd100, 16'd90, 16'd110);
    send_triple(16'hFFFF, 16'hFFFF, 16'h0000);
    send_triple(16'h0000, 16'hFFFF, 16'hFFFF);
    send_triple(16'hFFFF, 16'h0000, 16'hFFFF);
    send_triple(16'd12000, 16'd30000, 16'd500);
    send_triple(16'd500, 16'd30000, 16'd12000);
    send_triple(16'd8000, 16'd1, 16'd8000);

    random_phase(350);
    send_idle_pct = 59; recv_idle_pct = 25;
    random_phase(340);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(340);
    s_tvalid <= 0;
    sending_done = 1;

    // Wait for outstanding items, then let the pipeline settle
    while (board.pending.size() != 0 || hold_off) @(posedge clk);
    drain = 0;
    while (drain < 100) begin
      @(posedge clk);
      drain++;
    end

    $display("Checked %0d output items from %0d triples over three idle profiles,",
             board.checked, board.checked);
    $display("including directed extremes, zero-sum faults and a long output stall.");
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("rgb_to_colour_temperature_lux test passed");
    else
      $display("rgb_to_colour_temperature_lux test failed");
    $finish;
  end
endmodule
